>>> hdl/prc_pkg.sv
package prc_pkg;

  localparam int ITERATIONS_DEF   = 16;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // angle input, Q3.13 radians
  localparam int ANGLE_W = 16;
  localparam logic signed [ANGLE_W-1:0] ANGLE_PI      = 16'sd25736;
  localparam logic signed [ANGLE_W-1:0] ANGLE_HALF_PI = 16'sd12868;
  // angle accumulator counts 2^-20 rad: rotor_angle * 128
  localparam int ANGLE_SHIFT = 7;
  localparam int Z_W         = 24;

  // cos/sin datapath, units of 2^-24
  localparam int TRIG_FRAC  = 24;
  localparam int TRIG_W     = 27;
  localparam int TABLE_STEPS = 24;

  localparam logic signed [Z_W-1:0] ATAN_TABLE [TABLE_STEPS] = '{
    24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396,
    24'sd65451,  24'sd32757,  24'sd16383,  24'sd8192,
    24'sd4096,   24'sd2048,   24'sd1024,   24'sd512,
    24'sd256,    24'sd128,    24'sd64,     24'sd32,
    24'sd16,     24'sd8,      24'sd4,      24'sd2,
    24'sd1,      24'sd0,      24'sd0,      24'sd0
  };

  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [Z_W-1:0]    z;
    logic signed [Z_W-1:0]    target;
  } cordic_t;

  // CORDIC gain K * 2^24 for the given step count
  function automatic logic signed [TRIG_W-1:0] cordic_gain(input int steps);
    logic signed [TRIG_W-1:0] g;
    if (steps <= 8)       g = 27'sd10188117;
    else if (steps == 9)  g = 27'sd10188040;
    else if (steps == 10) g = 27'sd10188020;
    else if (steps == 11) g = 27'sd10188015;
    else                  g = 27'sd10188014;
    return g;
  endfunction

endpackage

>>> hdl/prc_cordic_stage.sv
module prc_cordic_stage
  import prc_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic    clk,
  input  cordic_t d,
  output cordic_t q
);

  logic signed [TRIG_W-1:0] xs;
  logic signed [TRIG_W-1:0] ys;
  logic signed [TRIG_W-1:0] dx;
  logic signed [TRIG_W-1:0] dy;
  logic signed [Z_W-1:0]    zs;
  logic signed [Z_W-1:0]    ts;
  cordic_t                  q_next;

  always_comb begin
    xs = d.x;
    ys = d.y;
    zs = d.z;
    ts = d.target;
    // arithmetic shift: floor rounding
    dx = ys >>> STEP;
    dy = xs >>> STEP;
    q_next.target = ts;
    if (zs < ts) begin
      q_next.z = zs + ATAN_TABLE[STEP];
      q_next.x = xs - dx;
      q_next.y = ys + dy;
    end else begin
      q_next.z = zs - ATAN_TABLE[STEP];
      q_next.x = xs + dx;
      q_next.y = ys - dy;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

>>> hdl/park_rotation_cordic_unit.sv
// Park / inverse Park rotation. One item per clock: an item is taken whenever
// start is high (busy is always low). Its result shows on first_result,
// second_result and saturated for one cycle with done high. The result passes
// through the rotation pipeline: the angle-fold register loads at the accepting
// edge, then one register per CORDIC step, then the multiply, add and
// round/saturate stages. Items leave in the order they came.
// The receiver must take each result when done is high.
// mode 0: d = a*cos + b*sin, q = b*cos - a*sin; mode 1: alpha = d*cos - q*sin,
// beta = d*sin + q*cos. Angles are clamped to +/-pi.
module park_rotation_cordic_unit
  import prc_pkg::*;
#(
  parameter int ITERATIONS   = ITERATIONS_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           mode,
  input  logic signed [SAMPLE_WIDTH-1:0] first_component,
  input  logic signed [SAMPLE_WIDTH-1:0] second_component,
  input  logic signed [ANGLE_W-1:0]      rotor_angle,
  output logic                           done,
  output logic signed [SAMPLE_WIDTH-1:0] first_result,
  output logic signed [SAMPLE_WIDTH-1:0] second_result,
  output logic                           saturated
);

  localparam int SW      = SAMPLE_WIDTH;
  localparam int PROD_W  = SW + TRIG_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int RND_W   = SUM_W - TRIG_FRAC;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(2 ** (TRIG_FRAC - 1));
  localparam logic signed [SW-1:0] SAT_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_MIN = {1'b1, {(SW-1){1'b0}}};

  assign busy = 1'b0;

  // ---------------- angle clamp and fold ----------------
  logic signed [ANGLE_W-1:0] ang_clamp;
  logic signed [ANGLE_W-1:0] ang_fold;
  logic                      flip_next;

  always_comb begin
    priority if (rotor_angle > ANGLE_PI)   ang_clamp = ANGLE_PI;
    else if (rotor_angle < -ANGLE_PI)      ang_clamp = -ANGLE_PI;
    else                                   ang_clamp = rotor_angle;
    priority if (ang_clamp > ANGLE_HALF_PI) begin
      ang_fold  = ang_clamp - ANGLE_PI;
      flip_next = 1'b1;
    end else if (ang_clamp < -ANGLE_HALF_PI) begin
      ang_fold  = ang_clamp + ANGLE_PI;
      flip_next = 1'b1;
    end else begin
      ang_fold  = ang_clamp;
      flip_next = 1'b0;
    end
  end

  // side data that rides along the CORDIC stages
  logic                 vld      [0:ITERATIONS];
  logic                 flip_p   [0:ITERATIONS];
  logic                 mode_p   [0:ITERATIONS];
  logic signed [SW-1:0] a_p      [0:ITERATIONS];
  logic signed [SW-1:0] b_p      [0:ITERATIONS];
  logic signed [Z_W-1:0] target0;
  cordic_t              cstage   [0:ITERATIONS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= start;
    end
    flip_p[0] <= flip_next;
    mode_p[0] <= mode;
    a_p[0]    <= first_component;
    b_p[0]    <= second_component;
    target0   <= Z_W'(ang_fold) <<< ANGLE_SHIFT;
  end

  always_comb begin
    cstage[0].x      = cordic_gain(ITERATIONS);
    cstage[0].y      = '0;
    cstage[0].z      = '0;
    cstage[0].target = target0;
  end

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_step
    prc_cordic_stage #(
      .STEP(i)
    ) u_stage (
      .clk(clk),
      .d  (cstage[i]),
      .q  (cstage[i+1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      flip_p[i+1] <= flip_p[i];
      mode_p[i+1] <= mode_p[i];
      a_p[i+1]    <= a_p[i];
      b_p[i+1]    <= b_p[i];
    end
  end

  // ---------------- products ----------------
  logic signed [TRIG_W-1:0] cos_v;
  logic signed [TRIG_W-1:0] sin_v;
  logic signed [PROD_W-1:0] p_ac, p_bs, p_bc, p_as;
  logic                     prod_vld, prod_mode;

  always_comb begin
    cos_v = flip_p[ITERATIONS] ? -cstage[ITERATIONS].x : cstage[ITERATIONS].x;
    sin_v = flip_p[ITERATIONS] ? -cstage[ITERATIONS].y : cstage[ITERATIONS].y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= vld[ITERATIONS];
    end
    prod_mode <= mode_p[ITERATIONS];
    p_ac <= a_p[ITERATIONS] * cos_v;
    p_bs <= b_p[ITERATIONS] * sin_v;
    p_bc <= b_p[ITERATIONS] * cos_v;
    p_as <= a_p[ITERATIONS] * sin_v;
  end

  // ---------------- sums ----------------
  logic signed [SUM_W-1:0] sum0, sum1;
  logic                    sum_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_vld <= 1'b0;
    end else begin
      sum_vld <= prod_vld;
    end
    if (prod_mode) begin
      sum0 <= SUM_W'(p_ac) - SUM_W'(p_bs);
      sum1 <= SUM_W'(p_as) + SUM_W'(p_bc);
    end else begin
      sum0 <= SUM_W'(p_ac) + SUM_W'(p_bs);
      sum1 <= SUM_W'(p_bc) - SUM_W'(p_as);
    end
  end

  // ---------------- round and saturate ----------------
  logic signed [SUM_W-1:0] rs0, rs1;
  logic signed [RND_W-1:0] rnd0, rnd1;
  logic                    ovf0, ovf1;
  logic signed [SW-1:0]    res0, res1;

  always_comb begin
    rs0  = (sum0 + ROUND_HALF) >>> TRIG_FRAC;
    rs1  = (sum1 + ROUND_HALF) >>> TRIG_FRAC;
    rnd0 = rs0[RND_W-1:0];
    rnd1 = rs1[RND_W-1:0];
    // in range when all bits from the sample sign up agree
    ovf0 = !((&rnd0[RND_W-1:SW-1]) || !(|rnd0[RND_W-1:SW-1]));
    ovf1 = !((&rnd1[RND_W-1:SW-1]) || !(|rnd1[RND_W-1:SW-1]));
    if (ovf0) res0 = rnd0[RND_W-1] ? SAT_MIN : SAT_MAX;
    else      res0 = rnd0[SW-1:0];
    if (ovf1) res1 = rnd1[RND_W-1] ? SAT_MIN : SAT_MAX;
    else      res1 = rnd1[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sum_vld;
    end
    first_result  <= res0;
    second_result <= res1;
    saturated     <= ovf0 | ovf1;
  end

endmodule

>>> tb/prc_tb_pkg.sv
`timescale 1ns / 100ps
package prc_tb_pkg;

  typedef enum logic {
    MODE_PARK     = 1'b0,
    MODE_INV_PARK = 1'b1
  } rotation_mode_t;

endpackage

>>> tb/park_rotation_cordic_checker.sv
`timescale 1ns / 100ps
module park_rotation_cordic_checker
  import prc_pkg::*;
  import prc_tb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               mode,
  input  logic signed [15:0] first_component,
  input  logic signed [15:0] second_component,
  input  logic signed [15:0] rotor_angle,
  input  logic               done,
  input  logic signed [15:0] first_result,
  input  logic signed [15:0] second_result,
  input  logic               saturated,
  output int                 fail_count,
  output int                 pending,
  output int                 results_checked,
  output int                 saturated_seen
);

  localparam int     ROT_STEPS  = 16;
  // K * 2^24 for 16 steps
  localparam longint ROT_GAIN   = 64'sd10188014;
  localparam longint ROUND_HALF = 64'sd1 << (TRIG_FRAC - 1);
  localparam longint Q15_MAX    = 64'sd32767;
  localparam longint Q15_MIN    = -64'sd32768;
  localparam int     PRINT_CAP  = 40;

  typedef struct packed {
    logic signed [15:0] first_result;
    logic signed [15:0] second_result;
    logic               saturated;
  } park_result_t;

  park_result_t rotation_q[$];

  // atan(2^-i) in units of 2^-20 rad
  function automatic longint atan_step(input int i);
    case (i)
      0:       return 823550;
      1:       return 486170;
      2:       return 256879;
      3:       return 130396;
      4:       return 65451;
      5:       return 32757;
      6:       return 16383;
      default: return longint'(8192) >>> (i - 7);
    endcase
  endfunction

  function automatic logic signed [15:0] round_to_q15(input longint acc, output logic clipped);
    longint r;
    r = (acc + ROUND_HALF) >>> TRIG_FRAC;
    clipped = 1'b0;
    if (r > Q15_MAX) begin
      clipped = 1'b1;
      r = Q15_MAX;
    end else if (r < Q15_MIN) begin
      clipped = 1'b1;
      r = Q15_MIN;
    end
    return r[15:0];
  endfunction

  function automatic park_result_t predict_rotation(input logic rot_mode,
                                                    input logic signed [15:0] a_in,
                                                    input logic signed [15:0] b_in,
                                                    input logic signed [15:0] ang_in);
    park_result_t res;
    longint ang, target, z, x, y, dx, dy, c, s, a, b;
    logic flip, clip0, clip1;
    int i;
    ang = ang_in;
    flip = 1'b0;
    if (ang > ANGLE_PI) ang = ANGLE_PI;
    if (ang < -ANGLE_PI) ang = -ANGLE_PI;
    // fold into +/-pi/2; exactly pi/2 stays put
    if (ang > ANGLE_HALF_PI) begin
      ang = ang - ANGLE_PI;
      flip = 1'b1;
    end else if (ang < -ANGLE_HALF_PI) begin
      ang = ang + ANGLE_PI;
      flip = 1'b1;
    end
    target = ang <<< ANGLE_SHIFT;
    z = 0;
    x = ROT_GAIN;
    y = 0;
    for (i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z < target) begin
        z = z + atan_step(i);
        x = x - dx;
        y = y + dy;
      end else begin
        z = z - atan_step(i);
        x = x + dx;
        y = y - dy;
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    a = a_in;
    b = b_in;
    if (rot_mode == MODE_PARK) begin
      res.first_result  = round_to_q15(a * c + b * s, clip0);
      res.second_result = round_to_q15(b * c - a * s, clip1);
    end else begin
      res.first_result  = round_to_q15(a * c - b * s, clip0);
      res.second_result = round_to_q15(a * s + b * c, clip1);
    end
    res.saturated = clip0 | clip1;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= PRINT_CAP)
      $display("%0t ns: mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin
    park_result_t exp_res;
    if (!rst) begin
      // retire first so a result is never matched to an item taken on the same edge
      if (done) begin
        if (rotation_q.size() == 0) begin
          report_mismatch("result strobe with no item outstanding");
        end else begin
          exp_res = rotation_q.pop_front();
          results_checked++;
          if (saturated === 1'b1) saturated_seen++;
          if (first_result !== exp_res.first_result)
            report_mismatch($sformatf("first_result %0d, expected %0d",
                                      first_result, exp_res.first_result));
          if (second_result !== exp_res.second_result)
            report_mismatch($sformatf("second_result %0d, expected %0d",
                                      second_result, exp_res.second_result));
          if (saturated !== exp_res.saturated)
            report_mismatch($sformatf("saturated %b, expected %b",
                                      saturated, exp_res.saturated));
        end
      end
      if (start && !busy)
        rotation_q.push_back(predict_rotation(mode, first_component, second_component,
                                              rotor_angle));
      pending = rotation_q.size();
    end
  end

endmodule

>>> tb/tb_park_rotation_cordic_unit.sv
`timescale 1ns / 100ps
module tb_park_rotation_cordic_unit
  import prc_pkg::*;
  import prc_tb_pkg::*;
();

  localparam int ITEM_COUNT   = 1600;
  localparam int QUIET_TAIL   = 300;
  localparam int DRAIN_CYCLES = 48;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic signed [15:0] SAMPLE_MAX   = 16'sh7FFF;
  localparam logic signed [15:0] SAMPLE_MIN   = 16'sh8000;
  localparam logic signed [15:0] QUARTER_PI   = ANGLE_HALF_PI >>> 1;
  localparam logic signed [15:0] ANGLE_MAX_IN = 16'sh7FFF;
  localparam logic signed [15:0] ANGLE_MIN_IN = 16'sh8000;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               mode;
  logic signed [15:0] first_component;
  logic signed [15:0] second_component;
  logic signed [15:0] rotor_angle;
  logic               done;
  logic signed [15:0] first_result;
  logic signed [15:0] second_result;
  logic               saturated;

  int fail_count;
  int pending;
  int results_checked;
  int saturated_seen;
  int cycle_count = 0;
  int items_sent = 0;
  int clamped_sent = 0;
  int drains = 0;

  park_rotation_cordic_unit u_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .mode             (mode),
    .first_component  (first_component),
    .second_component (second_component),
    .rotor_angle      (rotor_angle),
    .done             (done),
    .first_result     (first_result),
    .second_result    (second_result),
    .saturated        (saturated)
  );

  park_rotation_cordic_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .mode             (mode),
    .first_component  (first_component),
    .second_component (second_component),
    .rotor_angle      (rotor_angle),
    .done             (done),
    .first_result     (first_result),
    .second_result    (second_result),
    .saturated        (saturated),
    .fail_count       (fail_count),
    .pending          (pending),
    .results_checked  (results_checked),
    .saturated_seen   (saturated_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("park_rotation_cordic_unit test failed");
      $finish;
    end
  end

  task automatic send_item(input rotation_mode_t m, input logic signed [15:0] a,
                           input logic signed [15:0] b, input logic signed [15:0] ang);
    start            <= 1'b1;
    mode             <= m;
    first_component  <= a;
    second_component <= b;
    rotor_angle      <= ang;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (ang > ANGLE_PI || ang < -ANGLE_PI) clamped_sent++;
  endtask

  // start low with junk on the fields
  task automatic idle_burst();
    start            <= 1'b0;
    mode             <= 1'($urandom_range(0, 1));
    first_component  <= 16'($urandom);
    second_component <= 16'($urandom);
    rotor_angle      <= 16'($urandom);
    repeat ($urandom_range(1, 17)) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    drains++;
  endtask

  function automatic logic signed [15:0] pick_sample();
    logic signed [15:0] v;
    case ($urandom_range(0, 15))
      0:       v = SAMPLE_MAX;
      1:       v = SAMPLE_MIN;
      2:       v = 16'sd0;
      3:       v = -16'sd1;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] pick_angle();
    logic signed [15:0] v;
    case ($urandom_range(0, 19))
      0, 1:    v = 16'($urandom);
      2:       v = ANGLE_HALF_PI + 16'($urandom_range(0, 2)) - 16'sd1;
      3:       v = -ANGLE_HALF_PI + 16'($urandom_range(0, 2)) - 16'sd1;
      4:       v = ANGLE_PI - 16'($urandom_range(0, 1));
      5:       v = -ANGLE_PI + 16'($urandom_range(0, 1));
      default: v = 16'($urandom_range(0, 2 * 25736)) - ANGLE_PI;
    endcase
    return v;
  endfunction

  initial begin
    rotation_mode_t m;
    int k;
    rst              <= 1'b1;
    start            <= 1'b0;
    mode             <= MODE_PARK;
    first_component  <= 16'sd0;
    second_component <= 16'sd0;
    rotor_angle      <= 16'sd0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, fold boundaries, clamping, saturation
    send_item(MODE_PARK,     16'sd0,     16'sd0,     16'sd0);
    send_item(MODE_PARK,     SAMPLE_MAX, 16'sd0,     16'sd0);
    send_item(MODE_INV_PARK, SAMPLE_MIN, 16'sd0,     16'sd0);
    send_item(MODE_PARK,     SAMPLE_MAX, SAMPLE_MAX, QUARTER_PI);
    send_item(MODE_INV_PARK, SAMPLE_MAX, SAMPLE_MIN, QUARTER_PI);
    send_item(MODE_PARK,     SAMPLE_MIN, SAMPLE_MIN, -QUARTER_PI);
    send_item(MODE_INV_PARK, SAMPLE_MIN, SAMPLE_MAX, -QUARTER_PI);
    send_item(MODE_PARK,     16'sd16384, -16'sd16384, ANGLE_HALF_PI);
    send_item(MODE_INV_PARK, 16'sd16384, 16'sd8192,  -ANGLE_HALF_PI);
    send_item(MODE_PARK,     -16'sd1,    -16'sd1,    ANGLE_HALF_PI + 16'sd1);
    send_item(MODE_INV_PARK, 16'sd12345, -16'sd321,  ANGLE_HALF_PI + 16'sd1);
    send_item(MODE_PARK,     16'sd20000, 16'sd10000, -ANGLE_HALF_PI - 16'sd1);
    send_item(MODE_INV_PARK, -16'sd7000, 16'sd30000, -ANGLE_HALF_PI - 16'sd1);
    send_item(MODE_PARK,     SAMPLE_MAX, SAMPLE_MIN, ANGLE_PI);
    send_item(MODE_INV_PARK, SAMPLE_MIN, SAMPLE_MAX, -ANGLE_PI);
    idle_burst();
    send_item(MODE_PARK,     16'sd11111, 16'sd22222, ANGLE_PI + 16'sd1);
    send_item(MODE_INV_PARK, 16'sd11111, 16'sd22222, -ANGLE_PI - 16'sd1);
    send_item(MODE_PARK,     -16'sd5000, 16'sd9000,  ANGLE_MAX_IN);
    send_item(MODE_INV_PARK, -16'sd5000, 16'sd9000,  ANGLE_MIN_IN);
    send_item(MODE_PARK,     SAMPLE_MAX, SAMPLE_MAX, ANGLE_MAX_IN);
    send_item(MODE_INV_PARK, SAMPLE_MIN, SAMPLE_MIN, ANGLE_MIN_IN);
    send_item(MODE_PARK,     -16'sd1,    SAMPLE_MAX, -16'sd1);
    wait_for_drain();

    for (k = 0; k < ITEM_COUNT; k++) begin
      // idle only in two of every three stretches, never in the tail
      if (k < ITEM_COUNT - QUIET_TAIL && (k / 150) % 3 != 2 && $urandom_range(0, 3) == 0)
        idle_burst();
      if (k == ITEM_COUNT / 2)
        wait_for_drain();
      m = $urandom_range(0, 1) ? MODE_INV_PARK : MODE_PARK;
      send_item(m, pick_sample(), pick_sample(), pick_angle());
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d items (%0d with angles beyond pi) in both rotation modes;",
             items_sent, clamped_sent);
    $display("%0d results checked, %0d saturated.", results_checked, saturated_seen);
    $display("Sender idled in bursts, drained the pipeline %0d times, ran the last %0d %s",
             drains, QUIET_TAIL, "items back to back.");
    if (fail_count == 0) begin
      $display("park_rotation_cordic_unit test passed");
    end else begin
      $display("park_rotation_cordic_unit test failed");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/prc_pkg.sv
hdl/prc_cordic_stage.sv
hdl/park_rotation_cordic_unit.sv
tb/prc_tb_pkg.sv
tb/park_rotation_cordic_checker.sv
tb/tb_park_rotation_cordic_unit.sv
